/* rtl/core/u8s_pkg.sv */
`default_nettype none

package u8s_pkg;

  localparam logic [7:0] ByteTab      = 8'h09;
  localparam logic [7:0] ByteLf       = 8'h0A;
  localparam logic [7:0] AsciiLo      = 8'h20;
  localparam logic [7:0] AsciiHi      = 8'h7F;
  localparam logic [7:0] ContLo       = 8'h80;
  localparam logic [7:0] ContHi       = 8'hBF;
  localparam logic [7:0] Lead2Lo      = 8'hC2;
  localparam logic [7:0] Lead2Hi      = 8'hDF;
  localparam logic [7:0] Lead3Lo      = 8'hE0;
  localparam logic [7:0] Lead3Hi      = 8'hEF;
  localparam logic [7:0] LeadE0       = 8'hE0;
  localparam logic [7:0] LeadEd       = 8'hED;
  localparam logic [7:0] E0SecondLo   = 8'hA0;
  localparam logic [7:0] EdSecondHi   = 8'h9F;
  localparam logic [7:0] Lead4Lo      = 8'hF1;
  localparam logic [7:0] Lead4Hi      = 8'hF4;
  localparam logic [1:0] SkipBytes    = 2'd3;

  localparam logic [1:0] HeldNone     = 2'd0;
  localparam logic [1:0] HeldLead     = 2'd1;
  localparam logic [1:0] HeldTwo      = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } u8s_in_t;

  typedef struct packed {
    logic [1:0] out_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       string_done;
  } u8s_out_t;

  function automatic logic is_single(input logic [7:0] b);
    return (b == ByteTab) || (b == ByteLf) || (b >= AsciiLo && b <= AsciiHi);
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= Lead2Lo && b <= Lead2Hi) || (b >= Lead3Lo && b <= Lead3Hi);
  endfunction

  function automatic logic is_skip_lead(input logic [7:0] b);
    return b >= Lead4Lo && b <= Lead4Hi;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b >= ContLo && b <= ContHi;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    if (lead == LeadE0) begin
      ok = b >= E0SecondLo && b <= ContHi;
    end else if (lead == LeadEd) begin
      ok = b >= ContLo && b <= EdSecondHi;
    end else begin
      ok = is_cont(b);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/u8s_in_if.sv */
`default_nettype none

interface u8s_in_if import u8s_pkg::*; ();
  logic    valid;
  logic    ready;
  u8s_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/u8s_out_if.sv */
`default_nettype none

interface u8s_out_if import u8s_pkg::*; ();
  logic     valid;
  logic     ready;
  u8s_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/utf8_sanitizer_drop_four_byte.sv */
// channel  | dir | payload
// in_i     | in  | in_byte[7:0], end_of_text
// out_o    | out | out_count[1:0], first_byte, second_byte, third_byte, string_done
//
// one item per cycle unless out_o stalls; each result is held in the result register
// the input register and the result register are the only pipeline stages
// decode state updates as an item moves from the input register to the result register
// a stall on out_o holds the result register, then the input register, then in_i.ready
// reset clears the valid flags and all held sequence and skip state
`default_nettype none

module utf8_sanitizer_drop_four_byte import u8s_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  u8s_in_if.sink      in_i,
  u8s_out_if.source   out_o
);

  logic       s1_valid_q;
  u8s_in_t    s1_q;
  logic       out_valid_q;
  u8s_out_t   out_q;
  u8s_out_t   out_d;

  logic [7:0] held_lead_q, held_lead_d;
  logic [7:0] held_second_q, held_second_d;
  logic [1:0] held_count_q, held_count_d;
  logic [1:0] skip_left_q, skip_left_d;

  logic       out_free;
  logic       adv;
  logic       accept;
  logic       start;
  logic [7:0] b;

  assign out_free    = !out_valid_q || out_o.ready;
  assign adv         = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || adv;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = s1_q.in_byte;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    held_lead_d     = held_lead_q;
    held_second_d   = held_second_q;
    held_count_d    = held_count_q;
    skip_left_d     = skip_left_q;
    out_d           = '0;
    out_d.string_done = s1_q.end_of_text;
    start           = 1'b0;

    if (skip_left_q != 2'd0) begin
      skip_left_d = skip_left_q - 2'd1;
    end else if (held_count_q == HeldLead) begin
      if (second_ok(held_lead_q, b)) begin
        if (held_lead_q <= Lead2Hi) begin
          out_d.out_count   = 2'd2;
          out_d.first_byte  = held_lead_q;
          out_d.second_byte = b;
          held_count_d      = HeldNone;
          held_lead_d       = '0;
        end else begin
          held_second_d = b;
          held_count_d  = HeldTwo;
        end
      end else begin
        held_count_d = HeldNone;
        held_lead_d  = '0;
        start        = 1'b1;
      end
    end else if (held_count_q == HeldTwo) begin
      held_count_d  = HeldNone;
      held_lead_d   = '0;
      held_second_d = '0;
      if (is_cont(b)) begin
        out_d.out_count   = 2'd3;
        out_d.first_byte  = held_lead_q;
        out_d.second_byte = held_second_q;
        out_d.third_byte  = b;
      end else begin
        start = 1'b1;
      end
    end else begin
      held_count_d = HeldNone;
      start        = 1'b1;
    end

    // byte decoded afresh: emitted as a single byte, held as a lead, starting a skip, or dropped
    if (start) begin
      if (is_single(b)) begin
        out_d.out_count  = 2'd1;
        out_d.first_byte = b;
      end else if (is_lead(b)) begin
        held_lead_d  = b;
        held_count_d = HeldLead;
      end else if (is_skip_lead(b)) begin
        skip_left_d = SkipBytes;
      end
    end

    if (s1_q.end_of_text) begin
      held_lead_d   = '0;
      held_second_d = '0;
      held_count_d  = HeldNone;
      skip_left_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      held_lead_q   <= '0;
      held_second_q <= '0;
      held_count_q  <= HeldNone;
      skip_left_q   <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q   <= 1'b1;
        held_lead_q   <= held_lead_d;
        held_second_q <= held_second_d;
        held_count_q  <= held_count_d;
        skip_left_q   <= skip_left_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i.data;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_no_held_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q != 2'd3)
    else $error("held count reached three");

  a_skip_excludes_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_left_q != 2'd0 |-> held_count_q == HeldNone)
    else $error("skip running with bytes held");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_q.end_of_text |=> held_count_q == HeldNone && skip_left_q == 2'd0)
    else $error("state left after end of string");

  a_unused_bytes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_count == 2'd0 |->
      out_q.first_byte == 8'd0 && out_q.second_byte == 8'd0 && out_q.third_byte == 8'd0)
    else $error("stray bytes in an empty result");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_q))
    else $error("input register lost an item under stall");
`endif

endmodule

`default_nettype wire
